// ----- sv/bom_pkg.sv -----
// Shared types, codes and helpers for the buffer occupancy monitor.
package bom_pkg;

	localparam int unsigned BITS_W   = 24;
	localparam int unsigned FILL_W   = 48;
	localparam int unsigned SUM_W    = FILL_W + 2;
	localparam int unsigned LEN_W    = 31;
	localparam int unsigned FRAME_W  = 24;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_TDATA_W  = 2 * BITS_W;
	localparam int unsigned OUT_TDATA_W = 80;

	localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_FILL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_TARGET  = 2'd2;

	localparam logic [LEN_W-1:0]   BUFFER_LENGTH_RST = 31'd1048576;
	localparam logic [LEN_W-1:0]   INITIAL_FILL_RST  = 31'd524288;
	localparam logic [FRAME_W-1:0] FRAME_TARGET_RST  = 24'd1;

	localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
	localparam logic signed [SUM_W-1:0] FILL_MAX_EXT = SUM_W'(50'sh0_7FFF_FFFF_FFFF);
	localparam logic signed [SUM_W-1:0] FILL_MIN_EXT = -FILL_MAX_EXT - SUM_W'(1);

	localparam logic [CODE_W-1:0] CODE_INIT      = 3'd0;
	localparam logic [CODE_W-1:0] CODE_NORMAL    = 3'd1;
	localparam logic [CODE_W-1:0] CODE_FINAL     = 3'd2;
	localparam logic [CODE_W-1:0] CODE_OVERFLOW  = 3'd3;
	localparam logic [CODE_W-1:0] CODE_UNDERFLOW = 3'd4;
	localparam logic [CODE_W-1:0] CODE_DONE      = 3'd5;

	typedef enum logic [5:0] {
		PH_INIT      = 6'b000001,
		PH_NORMAL    = 6'b000010,
		PH_FINAL     = 6'b000100,
		PH_OVERFLOW  = 6'b001000,
		PH_UNDERFLOW = 6'b010000,
		PH_DONE      = 6'b100000
	} phase_t;

	typedef struct packed {
		logic               frame_arrives;
		logic [BITS_W-1:0]  bits_out;
		logic [BITS_W-1:0]  bits_in;
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_target;
		logic [LEN_W-1:0]   initial_fill;
		logic [LEN_W-1:0]   buffer_length;
	} cfg_t;

	typedef struct packed {
		logic [FRAME_W-1:0]       frame_number;
		logic [CODE_W-1:0]        phase_before;
		logic [CODE_W-1:0]        phase_now;
		logic signed [FILL_W-1:0] fill_level;
	} result_t;

	function automatic logic [CODE_W-1:0] phase_code(input phase_t ph);
		logic [CODE_W-1:0] code;
		case (ph)
			PH_INIT:      code = CODE_INIT;
			PH_NORMAL:    code = CODE_NORMAL;
			PH_FINAL:     code = CODE_FINAL;
			PH_OVERFLOW:  code = CODE_OVERFLOW;
			PH_UNDERFLOW: code = CODE_UNDERFLOW;
			PH_DONE:      code = CODE_DONE;
			default:      code = CODE_INIT;
		endcase
		return code;
	endfunction

endpackage

// ----- sv/bom_cfg.sv -----
// Configuration register file for the buffer occupancy monitor.
module bom_cfg
	import bom_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [LEN_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.buffer_length <= BUFFER_LENGTH_RST;
			cfg_q.initial_fill  <= INITIAL_FILL_RST;
			cfg_q.frame_target  <= FRAME_TARGET_RST;
		end else if (wr_valid) begin
			case (wr_index)
				REG_BUFFER_LENGTH: cfg_q.buffer_length <= wr_data;
				REG_INITIAL_FILL:  cfg_q.initial_fill  <= wr_data;
				REG_FRAME_TARGET:  cfg_q.frame_target  <= wr_data[FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/bom_in_stage.sv -----
// Input register stage for incoming requests.
module bom_in_stage
	import bom_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  item_valid,
	input  logic  item_taken,
	output item_t item
);

	logic  valid_s1;
	item_t item_s1;

	assign in_ready = !valid_s1 || item_taken;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

// ----- sv/bom_core.sv -----
// Occupancy, frame count and phase update with the result register.
module bom_core
	import bom_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    item_valid,
	input  item_t   item,
	output logic    item_taken,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res
);

	logic signed [FILL_W-1:0] fill_q;
	logic [FRAME_W-1:0]       frames_q;
	phase_t                   phase_q;

	logic                     valid_s2;
	result_t                  res_s2;

	logic signed [SUM_W-1:0]  sum;
	logic signed [FILL_W-1:0] fill_nx;
	logic [FRAME_W-1:0]       frames_nx;
	phase_t                   phase_nx;
	logic                     adv;

	assign adv        = !valid_s2 || res_ready;
	assign item_taken = adv;

	always_comb begin
		sum = $signed({{(SUM_W-FILL_W){fill_q[FILL_W-1]}}, fill_q})
			+ $signed({{(SUM_W-BITS_W){1'b0}}, item.bits_in})
			- $signed({{(SUM_W-BITS_W){1'b0}}, item.bits_out});
		if (sum > FILL_MAX_EXT) begin
			fill_nx = FILL_MAX_EXT[FILL_W-1:0];
		end else if (sum < FILL_MIN_EXT) begin
			fill_nx = FILL_MIN_EXT[FILL_W-1:0];
		end else begin
			fill_nx = sum[FILL_W-1:0];
		end

		frames_nx = frames_q;
		if (item.frame_arrives && frames_q != FRAME_MAX) begin
			frames_nx = frames_q + FRAME_W'(1);
		end

		phase_nx = phase_q;
		if (fill_nx > $signed({{(FILL_W-LEN_W){1'b0}}, cfg.buffer_length})) begin
			phase_nx = PH_OVERFLOW;
		end else if (fill_nx[FILL_W-1]) begin
			phase_nx = (phase_q == PH_FINAL) ? PH_DONE : PH_UNDERFLOW;
		end else if (phase_q == PH_INIT
			&& fill_nx > $signed({{(FILL_W-LEN_W){1'b0}}, cfg.initial_fill})) begin
			phase_nx = PH_NORMAL;
		end else if (phase_q == PH_NORMAL && frames_nx == cfg.frame_target) begin
			phase_nx = PH_FINAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			frames_q <= '0;
			phase_q  <= PH_INIT;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= item_valid;
			if (item_valid) begin
				fill_q   <= fill_nx;
				frames_q <= frames_nx;
				phase_q  <= phase_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item_valid) begin
			res_s2.fill_level   <= fill_nx;
			res_s2.phase_now    <= phase_code(phase_nx);
			res_s2.phase_before <= phase_code(phase_q);
			res_s2.frame_number <= frames_nx;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

endmodule

// ----- sv/buffer_occupancy_monitor_top.sv -----
// Top level of the buffer occupancy monitor.
//
// Leaky-bucket check of a coded-stream buffer. Each request carries the bits
// entering and leaving and a frame flag; each yields one result with the
// saturating signed occupancy, the new and previous phase (0 init, 1 normal,
// 2 final, 3 overflow, 4 underflow, 5 done) and the saturating frame count.
// One request is taken per cycle while the result side is not stalled by m_tready;
// a request's result passes through the input register and then the update
// into the result register before it is presented on the output.
// Configuration writes take effect on the next cycle and are always accepted.
module buffer_occupancy_monitor_top
	import bom_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // bits_in[23:0], bits_out[47:24]
	input  logic                   s_tuser,   // frame_arrives[0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // fill_level[47:0], phase_now[50:48],
	                                          // phase_before[53:51],
	                                          // frame_number[77:54], zero[79:78]
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LEN_W-1:0]       cfg_data
);

	cfg_t    cfg;
	item_t   in_item;
	item_t   item;
	logic    item_valid;
	logic    item_taken;
	result_t res;

	assign cfg_ready = 1'b1;

	assign in_item.bits_in       = s_tdata[BITS_W-1:0];
	assign in_item.bits_out      = s_tdata[2*BITS_W-1:BITS_W];
	assign in_item.frame_arrives = s_tuser;

	bom_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	bom_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_item    (in_item),
		.item_valid (item_valid),
		.item_taken (item_taken),
		.item       (item)
	);

	bom_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item_valid (item_valid),
		.item       (item),
		.item_taken (item_taken),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res        (res)
	);

	assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, res};

endmodule
